/* design/smt_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// smt_pkg: shared types and codes of the slot map table
// Transaction payloads, operation codes and status codes.
// ---------------------------------------------------------------------------
package smt_pkg;

	localparam int HANDLE_W = 10;
	localparam int FIELD_W  = 32;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_ERASE  = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic [1:0] STS_OK   = 2'd0;
	localparam logic [1:0] STS_FULL = 2'd1;
	localparam logic [1:0] STS_DEAD = 2'd2;

	typedef struct packed {
		logic [1:0]                 op;
		logic [HANDLE_W-1:0]        handle_in;
		logic signed [FIELD_W-1:0]  col0_in;
		logic signed [FIELD_W-1:0]  col1_in;
		logic signed [FIELD_W-1:0]  col2_in;
		logic signed [FIELD_W-1:0]  col3_in;
	} req_t;

	typedef struct packed {
		logic [1:0]                 status;
		logic [HANDLE_W-1:0]        handle_out;
		logic                       live;
		logic signed [FIELD_W-1:0]  col0_out;
		logic signed [FIELD_W-1:0]  col1_out;
		logic signed [FIELD_W-1:0]  col2_out;
		logic signed [FIELD_W-1:0]  col3_out;
	} rsp_t;

endpackage
`default_nettype wire

/* design/smt_ram.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// smt_ram: simple dual-port synchronous RAM
// One write and one read per cycle; read data registered, held when idle.
// ---------------------------------------------------------------------------
module smt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* design/slot_map_table_core.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// slot_map_table_core: slot map with free list
// Insert into a full table finishes in LOOK1 and insert finishes in LOOK2;
// query, read and erase finish in LOOK2 or CHECK, an erase that moves the last row in MOVE.
// One transaction at a time, paced by the chain of dependent registered reads
// through the handle and dense index RAMs.
// Reset clears the counters and the sequencer; the RAMs keep their contents,
// the counters guard every read, so no clearing pass is needed.
// ---------------------------------------------------------------------------
module slot_map_table_core #(
	parameter int DEPTH     = 1024,
	parameter int COL_WIDTH = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire smt_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output smt_pkg::rsp_t      rsp
);

	import smt_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > HANDLE_W) ? CW : HANDLE_W;
	localparam int RW = 4 * COL_WIDTH;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_LOOK1 = 5'b00010,
		ST_LOOK2 = 5'b00100,
		ST_CHECK = 5'b01000,
		ST_MOVE  = 5'b10000
	} state_t;

	state_t          state_q, state_d;
	req_t            req_q;
	rsp_t            rsp_q, res;
	logic            rsp_valid_q;
	logic [CW-1:0]   free_q, free_d;
	logic [CW-1:0]   issued_q, issued_d;
	logic [CW-1:0]   live_q, live_d;
	logic [PW-1:0]   pos_q;

	logic            out_free, finish;
	logic [XW-1:0]   h_x;
	logic [CW-1:0]   last, nh;
	logic            full, reuse, ok, match;

	logic            row_we, row_re;
	logic [PW-1:0]   row_waddr, row_raddr;
	logic [RW-1:0]   row_wdata, row_rd;
	logic            h2d_we, h2d_re;
	logic [PW-1:0]   h2d_waddr, h2d_raddr;
	logic [CW-1:0]   h2d_wdata, h2d_rd;
	logic            d2h_we, d2h_re;
	logic [PW-1:0]   d2h_waddr, d2h_raddr;
	logic [PW-1:0]   d2h_wdata, d2h_rd;

	smt_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_row (
		.clk, .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
		.re(row_re), .raddr(row_raddr), .rdata(row_rd)
	);

	smt_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_h2d (
		.clk, .we(h2d_we), .waddr(h2d_waddr), .wdata(h2d_wdata),
		.re(h2d_re), .raddr(h2d_raddr), .rdata(h2d_rd)
	);

	smt_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_d2h (
		.clk, .we(d2h_we), .waddr(d2h_waddr), .wdata(d2h_wdata),
		.re(d2h_re), .raddr(d2h_raddr), .rdata(d2h_rd)
	);

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign h_x   = XW'(req_q.handle_in);
	assign last  = live_q - CW'(1);
	assign full  = (live_q == CW'(DEPTH));
	assign reuse = (free_q < issued_q);
	assign nh    = reuse ? free_q : issued_q;
	assign ok    = (h_x < XW'(issued_q)) && (h2d_rd < live_q);
	assign match = (XW'(d2h_rd) == h_x);

	always_comb begin
		state_d   = state_q;
		free_d    = free_q;
		issued_d  = issued_q;
		live_d    = live_q;
		finish    = 1'b0;
		row_we    = 1'b0;
		row_re    = 1'b0;
		row_waddr = '0;
		row_raddr = '0;
		row_wdata = '0;
		h2d_we    = 1'b0;
		h2d_re    = 1'b0;
		h2d_waddr = '0;
		h2d_raddr = '0;
		h2d_wdata = '0;
		d2h_we    = 1'b0;
		d2h_re    = 1'b0;
		d2h_waddr = '0;
		d2h_raddr = '0;
		d2h_wdata = '0;
		res            = '0;
		res.status     = STS_OK;
		res.handle_out = req_q.handle_in;

		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_LOOK1;
				end
			end
			ST_LOOK1: begin
				if (req_q.op == OP_INSERT && full) begin
					finish     = 1'b1;
					res.status = STS_FULL;
					if (out_free) begin
						state_d = ST_IDLE;
					end
				end else if (req_q.op == OP_INSERT) begin
					// append the row now, fetch the next free link
					row_we    = 1'b1;
					row_waddr = live_q[PW-1:0];
					row_wdata = {COL_WIDTH'($unsigned(req_q.col0_in)),
					             COL_WIDTH'($unsigned(req_q.col1_in)),
					             COL_WIDTH'($unsigned(req_q.col2_in)),
					             COL_WIDTH'($unsigned(req_q.col3_in))};
					h2d_re    = 1'b1;
					h2d_raddr = free_q[PW-1:0];
					state_d   = ST_LOOK2;
				end else begin
					h2d_re    = 1'b1;
					h2d_raddr = h_x[PW-1:0];
					state_d   = ST_LOOK2;
				end
			end
			ST_LOOK2: begin
				if (req_q.op == OP_INSERT) begin
					finish         = 1'b1;
					res.handle_out = HANDLE_W'(nh);
					res.live       = 1'b1;
					if (out_free) begin
						h2d_we    = 1'b1;
						h2d_waddr = nh[PW-1:0];
						h2d_wdata = live_q;
						d2h_we    = 1'b1;
						d2h_waddr = live_q[PW-1:0];
						d2h_wdata = nh[PW-1:0];
						live_d    = live_q + CW'(1);
						if (reuse) begin
							free_d = h2d_rd;
						end else begin
							issued_d = issued_q + CW'(1);
							free_d   = issued_q + CW'(1);
						end
						state_d = ST_IDLE;
					end
				end else if (!ok) begin
					finish = 1'b1;
					if (req_q.op != OP_QUERY) begin
						res.status = STS_DEAD;
					end
					if (out_free) begin
						state_d = ST_IDLE;
					end
				end else begin
					d2h_re    = 1'b1;
					d2h_raddr = h2d_rd[PW-1:0];
					row_re    = 1'b1;
					row_raddr = h2d_rd[PW-1:0];
					state_d   = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!match) begin
					finish = 1'b1;
					if (req_q.op != OP_QUERY) begin
						res.status = STS_DEAD;
					end
					if (out_free) begin
						state_d = ST_IDLE;
					end
				end else if (req_q.op != OP_ERASE) begin
					finish   = 1'b1;
					res.live = 1'b1;
					if (req_q.op == OP_READ) begin
						res.col0_out = FIELD_W'(row_rd[4*COL_WIDTH-1 -: COL_WIDTH]);
						res.col1_out = FIELD_W'(row_rd[3*COL_WIDTH-1 -: COL_WIDTH]);
						res.col2_out = FIELD_W'(row_rd[2*COL_WIDTH-1 -: COL_WIDTH]);
						res.col3_out = FIELD_W'(row_rd[COL_WIDTH-1 -: COL_WIDTH]);
					end
					if (out_free) begin
						state_d = ST_IDLE;
					end
				end else begin
					// erase: finishing here only when the hole is the last row
					finish = (pos_q == last[PW-1:0]);
					if (!finish || out_free) begin
						h2d_we    = 1'b1;
						h2d_waddr = h_x[PW-1:0];
						h2d_wdata = free_q;
						free_d    = CW'(h_x);
						live_d    = last;
						if (finish) begin
							state_d = ST_IDLE;
						end else begin
							d2h_re    = 1'b1;
							d2h_raddr = last[PW-1:0];
							row_re    = 1'b1;
							row_raddr = last[PW-1:0];
							state_d   = ST_MOVE;
						end
					end
				end
			end
			ST_MOVE: begin
				finish = 1'b1;
				if (out_free) begin
					// fill the hole with the last row and repoint its handle
					row_we    = 1'b1;
					row_waddr = pos_q;
					row_wdata = row_rd;
					d2h_we    = 1'b1;
					d2h_waddr = pos_q;
					d2h_wdata = d2h_rd;
					h2d_we    = 1'b1;
					h2d_waddr = d2h_rd;
					h2d_wdata = CW'(pos_q);
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			free_q      <= '0;
			issued_q    <= '0;
			live_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			free_q   <= free_d;
			issued_q <= issued_d;
			live_q   <= live_d;
			if (finish && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == ST_LOOK2) begin
			pos_q <= h2d_rd[PW-1:0];
		end
		if (finish && out_free) begin
			rsp_q <= res;
		end
	end

endmodule
`default_nettype wire

/* sim/tb_slot_map_table_core.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tb_slot_map_table_core: self-checking bench for the slot map table
// A driver feeds request transactions from a pending queue through the
// valid/stall handshake. A local model of the table works out each answer,
// and the monitor checks every accepted response against the oldest answer.
// Runs cover handle reuse, row moves on erase, a full table and dead handles.
// ---------------------------------------------------------------------------
module tb_slot_map_table_core;
	import smt_pkg::*;

	localparam int TABLE_DEPTH    = 1024;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 200;

	typedef struct {
		req_t stim;
		rsp_t want;
	} pending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	pending_t request_q [$];
	rsp_t     slot_answers_q [$];
	rsp_t     inflight_answer;
	pending_t next_item;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int answer_idx     = 0;
	int idle_cycles    = 0;

	// local copy of the slot map
	logic [FIELD_W-1:0]  row_cols [TABLE_DEPTH][4];
	logic [HANDLE_W-1:0] dense_handle [TABLE_DEPTH];
	logic [HANDLE_W:0]   handle_slot [TABLE_DEPTH];
	logic [HANDLE_W:0]   free_top;
	logic [HANDLE_W:0]   issued_cnt;
	logic [HANDLE_W:0]   live_cnt;

	slot_map_table_core #(
		.DEPTH     (TABLE_DEPTH),
		.COL_WIDTH (FIELD_W)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	function automatic logic handle_alive(logic [HANDLE_W-1:0] h);
		logic [HANDLE_W:0] pos;
		if ({1'b0, h} >= issued_cnt)
			return 1'b0;
		pos = handle_slot[h];
		if (pos >= live_cnt)
			return 1'b0;
		return dense_handle[pos[HANDLE_W-1:0]] == h;
	endfunction

	function automatic rsp_t apply_slot_op(req_t r);
		rsp_t o;
		logic [HANDLE_W:0] pos;
		logic [HANDLE_W:0] last;
		logic [HANDLE_W-1:0] nh;
		logic [HANDLE_W-1:0] moved;
		int k;
		o = '0;
		o.status = STS_OK;
		o.handle_out = r.handle_in;
		case (r.op)
			OP_INSERT: begin
				if (live_cnt >= TABLE_DEPTH) begin
					o.status = STS_FULL;
				end else begin
					pos = live_cnt;
					row_cols[pos][0] = r.col0_in;
					row_cols[pos][1] = r.col1_in;
					row_cols[pos][2] = r.col2_in;
					row_cols[pos][3] = r.col3_in;
					// free list empty: hand out a fresh handle
					if (free_top >= issued_cnt) begin
						nh = issued_cnt[HANDLE_W-1:0];
						issued_cnt = issued_cnt + 1'b1;
						free_top = issued_cnt;
					end else begin
						nh = free_top[HANDLE_W-1:0];
						free_top = handle_slot[nh];
					end
					handle_slot[nh] = pos;
					dense_handle[pos] = nh;
					live_cnt = live_cnt + 1'b1;
					o.handle_out = nh;
					o.live = 1'b1;
				end
			end
			OP_ERASE: begin
				if (!handle_alive(r.handle_in)) begin
					o.status = STS_DEAD;
				end else begin
					pos = handle_slot[r.handle_in];
					last = live_cnt - 1'b1;
					// fill the hole with the last dense row
					if (pos != last) begin
						moved = dense_handle[last];
						for (k = 0; k < 4; k++)
							row_cols[pos][k] = row_cols[last][k];
						dense_handle[pos] = moved;
						handle_slot[moved] = pos;
					end
					live_cnt = last;
					handle_slot[r.handle_in] = free_top;
					free_top = {1'b0, r.handle_in};
				end
			end
			OP_QUERY: begin
				o.live = handle_alive(r.handle_in);
			end
			OP_READ: begin
				if (!handle_alive(r.handle_in)) begin
					o.status = STS_DEAD;
				end else begin
					pos = handle_slot[r.handle_in];
					o.col0_out = row_cols[pos][0];
					o.col1_out = row_cols[pos][1];
					o.col2_out = row_cols[pos][2];
					o.col3_out = row_cols[pos][3];
					o.live = 1'b1;
				end
			end
		endcase
		return o;
	endfunction

	task automatic queue_item(logic [1:0] op, logic [HANDLE_W-1:0] h,
			logic [FIELD_W-1:0] c0, logic [FIELD_W-1:0] c1,
			logic [FIELD_W-1:0] c2, logic [FIELD_W-1:0] c3);
		pending_t p;
		p.stim.op = op;
		p.stim.handle_in = h;
		p.stim.col0_in = c0;
		p.stim.col1_in = c1;
		p.stim.col2_in = c2;
		p.stim.col3_in = c3;
		p.want = apply_slot_op(p.stim);
		request_q.insert(request_q.size(), p);
	endtask

	function automatic logic [FIELD_W-1:0] random_col();
		case ($urandom_range(15))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// mostly live handles, some freed ones, some arbitrary
	function automatic logic [HANDLE_W-1:0] pick_handle();
		int r;
		r = $urandom_range(99);
		if (live_cnt != 0 && r < 75)
			return dense_handle[$urandom_range(live_cnt - 1)];
		if (issued_cnt != 0 && r < 90)
			return HANDLE_W'($urandom_range(issued_cnt - 1));
		return HANDLE_W'($urandom_range(TABLE_DEPTH - 1));
	endfunction

	task automatic queue_insert();
		queue_item(OP_INSERT, HANDLE_W'($urandom_range(TABLE_DEPTH - 1)),
			random_col(), random_col(), random_col(), random_col());
	endtask

	task automatic queue_random(int count, int pct_insert, int pct_erase, int pct_query);
		int r;
		logic [1:0] op;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < pct_insert)
				op = OP_INSERT;
			else if (r < pct_insert + pct_erase)
				op = OP_ERASE;
			else if (r < pct_insert + pct_erase + pct_query)
				op = OP_QUERY;
			else
				op = OP_READ;
			if (op == OP_INSERT)
				queue_insert();
			else
				queue_item(op, pick_handle(), random_col(), random_col(),
					random_col(), random_col());
		end
	endtask

	// hold until every queued transaction has been answered
	task automatic drain_wait();
		while (request_q.size() != 0 || req_valid || slot_answers_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_mismatch(string msg);
		// keep the log short on a badly broken block
		if (mismatch_count < MAX_REPORTS)
			$display("MISMATCH response %0d: %s", answer_idx, msg);
		mismatch_count++;
	endtask

	task automatic check_answer(rsp_t got, rsp_t want);
		if (got.status !== want.status)
			report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
		if (got.handle_out !== want.handle_out)
			report_mismatch($sformatf("handle_out %0d, want %0d",
				got.handle_out, want.handle_out));
		if (got.live !== want.live)
			report_mismatch($sformatf("live %b, want %b", got.live, want.live));
		if (got.col0_out !== want.col0_out)
			report_mismatch($sformatf("col0 %h, want %h", got.col0_out, want.col0_out));
		if (got.col1_out !== want.col1_out)
			report_mismatch($sformatf("col1 %h, want %h", got.col1_out, want.col1_out));
		if (got.col2_out !== want.col2_out)
			report_mismatch($sformatf("col2 %h, want %h", got.col2_out, want.col2_out));
		if (got.col3_out !== want.col3_out)
			report_mismatch($sformatf("col3 %h, want %h", got.col3_out, want.col3_out));
	endtask

	// driver: advance only when the current transaction is taken or none is up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall)
				slot_answers_q.insert(slot_answers_q.size(), inflight_answer);
			if (!req_valid || !req_stall) begin
				if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_item = request_q.pop_front();
					inflight_answer = next_item.want;
					req <= next_item.stim;
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_stall <= 1'b0;
		else
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (slot_answers_q.size() == 0)
				report_mismatch("response with no transaction outstanding");
			else
				check_answer(rsp, slot_answers_q.pop_front());
			answer_idx++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("slot_map_table_core test failed");
				$finish;
			end
		end
	end

	initial begin
		free_top = '0;
		issued_cnt = '0;
		live_cnt = '0;

		send_idle_pct = 16;
		recv_stall_pct = 55;

		// dead handles on an empty table
		queue_item(OP_QUERY, 10'd0, '0, '0, '0, '0);
		queue_item(OP_READ, 10'd0, '0, '0, '0, '0);
		queue_item(OP_ERASE, 10'd1023, '0, '0, '0, '0);
		// column extremes, handle field ignored on insert
		queue_item(OP_INSERT, 10'd1023, 32'h7fff_ffff, 32'h8000_0000, '1, '0);
		queue_item(OP_INSERT, 10'd0, 32'h8000_0000, 32'h7fff_ffff, '0, '1);
		queue_insert();
		queue_insert();
		queue_item(OP_READ, 10'd0, '0, '0, '0, '0);
		queue_item(OP_READ, 10'd1, '0, '0, '0, '0);
		queue_item(OP_READ, 10'd3, '0, '0, '0, '0);
		queue_item(OP_QUERY, 10'd1, '0, '0, '0, '0);
		// erase from the middle moves the last row into the hole
		queue_item(OP_ERASE, 10'd1, '0, '0, '0, '0);
		queue_item(OP_READ, 10'd3, '0, '0, '0, '0);
		queue_item(OP_QUERY, 10'd1, '0, '0, '0, '0);
		queue_item(OP_READ, 10'd1, '0, '0, '0, '0);
		queue_item(OP_ERASE, 10'd1, '0, '0, '0, '0);
		// erase of the last row itself
		queue_item(OP_ERASE, 10'd2, '0, '0, '0, '0);
		// freed handles come back newest first, then a fresh one
		queue_insert();
		queue_insert();
		queue_insert();
		queue_item(OP_READ, 10'd1, '0, '0, '0, '0);
		queue_item(OP_READ, 10'd2, '0, '0, '0, '0);
		queue_item(OP_QUERY, 10'd4, '0, '0, '0, '0);
		queue_item(OP_QUERY, 10'd1023, '0, '0, '0, '0);

		queue_random(60, 35, 20, 15);
		drain_wait();

		send_idle_pct = 55;
		recv_stall_pct = 16;
		// fill the table, then push against the full limit
		while (live_cnt < TABLE_DEPTH)
			queue_insert();
		repeat (8) queue_insert();
		queue_random(20, 40, 20, 10);
		drain_wait();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_random(40, 20, 40, 15);
		drain_wait();

		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("slot_map_table_core test passed");
		else
			$display("slot_map_table_core test failed");
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
design/smt_pkg.sv
design/smt_ram.sv
design/slot_map_table_core.sv
sim/tb_slot_map_table_core.sv
